>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   // Operation requested by one input item.
   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_POP_BACK   = 2'd1,
      OP_PUSH_FRONT = 2'd2,
      OP_POP_FRONT  = 2'd3
   } op_type;

   // Result status.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] popped_value;
      status_type  status;
      logic        now_empty;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;   // carry out the operation of the item being transferred
      logic load;   // capture the finished result into the output register
   } cmd_type;

endpackage

>>> hw/rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// A result is captured in the completion state after its request transfer, once the output
// register is free. A new item is taken only after the last one has been captured.
// The output register lets the next request transfer while a result waits to be taken.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// The entry memory is not cleared; entries are only read after a push has written them.

module double_ended_queue_unit #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::rsp_type rsp_payload
);

   // The controller sequences each item through an execute cycle, in which the
   // memory is written or read and the front index and count are updated, and a
   // completion cycle, in which the result is captured once the output register
   // is free.
   deq_pkg::cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the ring buffer: a front index, an explicit entry count
   // (so a zero word is a valid entry) and the entry memory.
   deq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hw/rtl/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.exec     = 1'b0;
      cmd.load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/deq_dp.sv
`timescale 1ns / 1ps

module deq_dp #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  deq_pkg::cmd_type cmd,
   input  deq_pkg::req_type req_payload,
   output deq_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop_ok_ff, pop_ok_in;
   deq_pkg::status_type status_ff, status_in;
   deq_pkg::rsp_type    rsp_ff, rsp_in;

   logic                  full, empty;
   logic [SW-1:0]         sum, sum_m1;
   logic [AW-1:0]         back_pos, last_pos, front_dec, front_inc;
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [31:0]           pop_word;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // Ring positions: the sums stay below twice the depth, so one compare
   // and subtract wraps them.
   assign sum      = SW'(front_ff) + SW'(count_ff);
   assign sum_m1   = sum - SW'(1);
   assign back_pos = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
   assign last_pos = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   // Stored words keep the low DATA_WIDTH bits; results carry the low 32.
   assign ram_wdata = DATA_WIDTH'(req_payload.value);
   assign pop_word  = 32'(ram_rdata);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      pop_ok_in = pop_ok_ff;
      status_in = status_ff;
      rsp_in    = rsp_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_addr  = front_ff;
      if (cmd.exec) begin
         pop_ok_in = 1'b0;
         status_in = deq_pkg::ST_OK;
         case (req_payload.operation)
            deq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_addr  = back_pos;
                  count_in  = count_ff + CW'(1);
               end
            end
            deq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_addr  = front_dec;
                  front_in  = front_dec;
                  count_in  = count_ff + CW'(1);
               end
            end
            deq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  ram_addr  = last_pos;
                  pop_ok_in = 1'b1;
                  count_in  = count_ff - CW'(1);
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  ram_addr  = front_ff;
                  front_in  = front_inc;
                  pop_ok_in = 1'b1;
                  count_in  = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = deq_pkg::ST_OK;
            end
         endcase
      end
      if (cmd.load) begin
         rsp_in.popped_value = pop_ok_ff ? pop_word : 32'd0;
         rsp_in.status       = status_ff;
         rsp_in.now_empty    = empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
      pop_ok_ff <= pop_ok_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_payload = rsp_ff;

endmodule

>>> hw/rtl/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input deq_pkg::rsp_type rsp_payload
);

   // Items are handled one at a time: after a transfer the request side closes.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item was in progress");

   // A result valid that rises must follow its request transfer through the completion state.
   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching request transfer");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed or dropped");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> verif/deq_result_checker.sv
`timescale 1ns / 1ps

module deq_result_checker #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  deq_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  deq_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending_count,
   output int               checked_count,
   output int               full_count,
   output int               empty_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [31:0] WORD_MASK =
      (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DATA_WIDTH) - 64'd1);

   // Shadow copy of the deque: ring storage, front position and fill level.
   logic [31:0]    ring_words [DEPTH];
   logic [IDX_W-1:0] front_pos;
   logic [IDX_W:0]   fill_level;

   deq_pkg::rsp_type awaited_rsp[$];
   int      mismatches;
   int      results_seen;
   int      full_pushes;
   int      empty_pops;

   // Applies one operation to the shadow deque and returns the result it should give.
   function automatic deq_pkg::rsp_type deque_apply(input deq_pkg::req_type item);
      deq_pkg::rsp_type res;
      logic [31:0]      word;
      int               pos;
      res = '0;
      res.status = deq_pkg::ST_OK;
      word = item.value & WORD_MASK;
      case (item.operation)
         deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
            if (int'(fill_level) >= DEPTH) begin
               res.status = deq_pkg::ST_FULL;
            end else if (item.operation == deq_pkg::OP_PUSH_BACK) begin
               pos = (int'(front_pos) + int'(fill_level)) % DEPTH;
               ring_words[pos] = word;
               fill_level = fill_level + 1'b1;
            end else begin
               front_pos = IDX_W'((int'(front_pos) + DEPTH - 1) % DEPTH);
               ring_words[front_pos] = word;
               fill_level = fill_level + 1'b1;
            end
         end
         default: begin
            if (fill_level == 0) begin
               res.status = deq_pkg::ST_EMPTY;
            end else if (item.operation == deq_pkg::OP_POP_BACK) begin
               pos = (int'(front_pos) + int'(fill_level) - 1) % DEPTH;
               res.popped_value = ring_words[pos];
               fill_level = fill_level - 1'b1;
            end else begin
               res.popped_value = ring_words[front_pos];
               front_pos = IDX_W'((int'(front_pos) + 1) % DEPTH);
               fill_level = fill_level - 1'b1;
            end
         end
      endcase
      res.now_empty = (fill_level == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (reset) begin
         awaited_rsp.delete();
         front_pos = '0;
         fill_level = '0;
         mismatches = 0;
         results_seen = 0;
         full_pushes = 0;
         empty_pops = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: result transfer with nothing outstanding:",
                            " value %h status %0d empty %0b"},
                           rsp_payload.popped_value, rsp_payload.status,
                           rsp_payload.now_empty);
            end else begin
               want = awaited_rsp.pop_front();
               results_seen++;
               if (rsp_payload.popped_value !== want.popped_value ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.now_empty !== want.now_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: result %0d: expected value %h status %0d empty %0b,",
                               " got value %h status %0d empty %0b"},
                              results_seen, want.popped_value, want.status,
                              want.now_empty, rsp_payload.popped_value,
                              rsp_payload.status, rsp_payload.now_empty);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = deque_apply(req_payload);
            if (want.status == deq_pkg::ST_FULL) full_pushes++;
            if (want.status == deq_pkg::ST_EMPTY) empty_pops++;
            awaited_rsp.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending_count <= awaited_rsp.size();
      checked_count <= results_seen;
      full_count <= full_pushes;
      empty_count <= empty_pops;
   end

endmodule

>>> verif/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;
   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int IDLE_LIMIT = 2000;

   // Every input of the block starts at a known value.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   deq_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   deq_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_count;
   int empty_count;

   int ops_sent;
   int burst_left;
   int idle_cycles;
   int stall_tick;
   int stall_mode;

   double_ended_queue_unit #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // The checker keeps its own model of the deque, pairs every result transfer with the
   // oldest outstanding prediction and reports the running failure count back here.
   deq_result_checker #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .full_count(full_count),
      .empty_count(empty_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The receiver stalls on a pattern of its own, switching among random modes:
   // always ready, a coin toss, mostly stalled, or a fixed three-in-four rhythm. The
   // always-ready mode gives stretches where results drain with no back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         stall_tick <= 0;
         stall_mode <= 0;
         rsp_ready <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 50 == 49) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_tick % 4 != 0);
         endcase
      end
   end

   // The watchdog counts cycles in which neither channel completes a transfer. A correct
   // block never comes close to the limit, since the sender's gaps and the receiver's
   // stalls are both short.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
         $display("double_ended_queue_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one operation and returns at the clock edge where it is transferred. The
   // sender works in bursts: at the start of each burst it may drop valid for a random
   // gap, then keeps valid high for the whole burst. Now and then a long burst keeps
   // the block under full load.
   task automatic issue_op(input deq_pkg::op_type op, input logic [31:0] word);
      deq_pkg::req_type item;
      int      gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      item.operation = op;
      item.value = word;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ops_sent++;
   endtask

   // Holds the sender off until every transfer so far has been answered.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Random operations with a chosen share of pushes. A high share walks the deque up to
   // full and then keeps hitting it there; a low share drains it and keeps popping from
   // empty. Pops carry random words, which the block must ignore.
   task automatic run_phase(input int count, input int push_pct);
      deq_pkg::op_type op;
      logic [31:0]     word;
      int              pick;
      repeat (count) begin
         if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
         else
            op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
         pick = $urandom_range(0, 9);
         if (pick == 0) word = 32'h0000_0000;
         else if (pick == 1) word = 32'hFFFF_FFFF;
         else word = $urandom();
         issue_op(op, word);
      end
   endtask

   initial begin
      ops_sent = 0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Both pops on an empty deque, then a zero word stored and taken
      // back to show that zero is a real entry. Then words of all ones, alternating
      // bit patterns and the top bit alone go in at both ends and come out at both
      // ends, so the pop order tells front from back. A push at the front of an empty
      // deque makes the front position wrap below zero, and the pops at the back that
      // follow must find the words across that wrap.
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_POP_FRONT, $urandom());
      issue_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
      issue_op(deq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
      issue_op(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      issue_op(deq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
      issue_op(deq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5);
      issue_op(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_POP_FRONT, $urandom());
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_POP_FRONT, $urandom());
      issue_op(deq_pkg::OP_POP_FRONT, $urandom());
      issue_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
      issue_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      wait_until_drained();

      // Random part: fill to full, drain to empty, wander in the middle, then repeat the
      // fill and drain so the ring positions wrap at new offsets.
      run_phase(350, 95);
      wait_until_drained();
      run_phase(350, 5);
      run_phase(330, 50);
      wait_until_drained();
      run_phase(350, 95);
      run_phase(350, 5);

      // Let every outstanding result arrive, then keep clocking before the report so that a stray
      // extra result would still be caught.
      wait_until_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d operations, %0d results checked", ops_sent, checked_count);
      $display("%0d pushes met a full deque, %0d pops met an empty one",
               full_count, empty_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("double_ended_queue_unit regression: pass");
      end else begin
         $display("%0d failures, %0d results still outstanding", fail_count, pending_count);
         $display("double_ended_queue_unit regression: fail");
      end
      $finish;
   end

endmodule
